### rtl/alc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alc_pkg
// Shared types and constants for the attenuator level correction block.
// ----------------------------------------------------------------------------
package alc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_A       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_B     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADC_MIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_LEVEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DET_CORR_OFF = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEM_CORR_OFF = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT  = 3'd6;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_WRITE   = 1'b1;

    localparam logic [6:0]  LEVEL_MAX  = 7'd127;
    localparam logic [49:0] ROUND_HALF = 50'h8000;

    typedef struct packed {
        logic       en;
        logic [2:0] index;
        logic [7:0] temp;
        logic [7:0] corr;
    } tbl_wr_t;

endpackage
`default_nettype wire

### rtl/alc_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alc_table
// Temperature table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module alc_table #(
    parameter int TABLE_POINTS = 8,
    parameter int AW           = 3
) (
    input  wire logic           clk,
    input  wire alc_pkg::tbl_wr_t wr,
    input  wire logic [AW-1:0]  rd_addr,
    output logic signed [7:0]   rd_temp,
    output logic signed [7:0]   rd_corr
);

    logic [7:0] temps_mem [TABLE_POINTS];
    logic [7:0] corrs_mem [TABLE_POINTS];
    logic [7:0] rd_temp_reg;
    logic [7:0] rd_corr_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en && (32'(wr.index) < TABLE_POINTS))
        begin
            temps_mem[AW'(wr.index)] <= wr.temp;
            corrs_mem[AW'(wr.index)] <= wr.corr;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_temp_reg <= temps_mem[rd_addr];
        rd_corr_reg <= corrs_mem[rd_addr];
    end

    assign rd_temp = $signed(rd_temp_reg);
    assign rd_corr = $signed(rd_corr_reg);

endmodule
`default_nettype wire

### rtl/alc_det_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alc_det_map
// Detector map: sample * gain + offset in Q16.16, round half up, saturate.
// Two register stages: product, then sum and clamp.
// ----------------------------------------------------------------------------
module alc_det_map (
    input  wire logic               clk,
    input  wire logic [15:0]        sample,
    input  wire logic signed [31:0] gain,
    input  wire logic signed [31:0] offset,
    output logic [6:0]              level
);

    logic signed [48:0] prod_reg;
    logic signed [49:0] acc;
    logic [6:0]         level_reg;
    logic [6:0]         level_next;

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed({1'b0, sample}) * gain;
    end

    assign acc = 50'(prod_reg) + 50'(offset) + $signed(alc_pkg::ROUND_HALF);

    always_comb
    begin
        priority if (acc[49])
            level_next = 7'd0;
        else if (|acc[48:23])
            level_next = alc_pkg::LEVEL_MAX;
        else
            level_next = acc[22:16];
    end

    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
    end

    assign level = level_reg;

endmodule
`default_nettype wire

### rtl/attenuator_level_correction.sv
`default_nettype none
// ----------------------------------------------------------------------------
// attenuator_level_correction
// Detector level plus table-based temperature correction, clamped to 0..127.
// ----------------------------------------------------------------------------
// A measurement item (op 0) is accepted only while the block is idle and
// passes through a load step, a table search and a sum step. The search
// ends at once when temperature correction is off or no points are set;
// otherwise it walks the table points. The search visits one point per cycle
// through the registered read port of the table memory, and the detector
// multiply and clamp run alongside it. A result still waiting in the output
// register holds the block in its last step. A table write item (op 1) is
// written on acceptance, leaves the block idle and gives no result. The
// finished result sits in an output register, so the next item can be
// accepted while it waits to be taken.
// ----------------------------------------------------------------------------
module attenuator_level_correction #(
    parameter int TABLE_POINTS = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [alc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [alc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               op,
    input  wire logic [15:0]                        adc_sample,
    input  wire logic signed [7:0]                  temperature,
    input  wire logic [2:0]                         entry_index,
    input  wire logic signed [7:0]                  entry_temp,
    input  wire logic signed [7:0]                  entry_corr,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [6:0]                              att_level,
    output logic [6:0]                              det_level,
    output logic signed [7:0]                       temp_corr,
    output logic                                    held
);

    localparam int AW = (TABLE_POINTS > 1) ? $clog2(TABLE_POINTS) : 1;
    localparam int CW = $clog2(TABLE_POINTS + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOAD   = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_SUM    = 2'd3;

    logic signed [31:0] gain_a_reg;
    logic signed [31:0] offset_b_reg;
    logic [15:0]        adc_min_reg;
    logic [6:0]         start_level_reg;
    logic               det_off_reg;
    logic               tem_off_reg;
    logic [3:0]         point_count_reg;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [AW-1:0]      idx_reg;
    logic [AW-1:0]      idx_next;
    logic [AW-1:0]      last_reg;
    logic               skip_reg;
    logic [15:0]        sample_reg;
    logic signed [7:0]  temp_reg;
    logic signed [7:0]  corr_reg;
    logic signed [7:0]  corr_next;
    logic [6:0]         prev_det_reg;

    logic               out_valid_reg;
    logic [6:0]         att_level_reg;
    logic [6:0]         det_level_reg;
    logic signed [7:0]  temp_corr_reg;
    logic               held_reg;

    logic               in_accept;
    logic               out_free;
    logic [CW-1:0]      n_eff;
    logic [AW-1:0]      rd_addr;
    logic signed [7:0]  rd_temp;
    logic signed [7:0]  rd_corr;
    logic [6:0]         map_level;
    alc_pkg::tbl_wr_t   tbl_wr;

    logic               hold_now;
    logic [6:0]         det_now;
    logic signed [8:0]  sum_now;
    logic [6:0]         att_now;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_a_reg      <= '0;
            offset_b_reg    <= '0;
            adc_min_reg     <= '0;
            start_level_reg <= '0;
            det_off_reg     <= 1'b0;
            tem_off_reg     <= 1'b0;
            point_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                alc_pkg::REG_GAIN_A:       gain_a_reg      <= $signed(cfg_data);
                alc_pkg::REG_OFFSET_B:     offset_b_reg    <= $signed(cfg_data);
                alc_pkg::REG_ADC_MIN:      adc_min_reg     <= cfg_data[15:0];
                alc_pkg::REG_START_LEVEL:  start_level_reg <= cfg_data[6:0];
                alc_pkg::REG_DET_CORR_OFF: det_off_reg     <= cfg_data[0];
                alc_pkg::REG_TEM_CORR_OFF: tem_off_reg     <= cfg_data[0];
                alc_pkg::REG_POINT_COUNT:  point_count_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign n_eff = (32'(point_count_reg) > TABLE_POINTS) ? CW'(TABLE_POINTS)
                                                         : CW'(point_count_reg);

    assign tbl_wr.en    = in_accept && (op == alc_pkg::OP_WRITE);
    assign tbl_wr.index = entry_index;
    assign tbl_wr.temp  = entry_temp;
    assign tbl_wr.corr  = entry_corr;

    always_comb
    begin
        unique case (state_reg)
            ST_LOAD:   rd_addr = '0;
            ST_SEARCH: rd_addr = (idx_reg == last_reg) ? idx_reg : idx_reg + 1'b1;
            default:   rd_addr = idx_reg;
        endcase
    end

    alc_table #(
        .TABLE_POINTS (TABLE_POINTS),
        .AW           (AW)
    ) u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd_addr (rd_addr),
        .rd_temp (rd_temp),
        .rd_corr (rd_corr)
    );

    alc_det_map u_det_map (
        .clk    (clk),
        .sample (sample_reg),
        .gain   (gain_a_reg),
        .offset (offset_b_reg),
        .level  (map_level)
    );

    assign hold_now = !det_off_reg && (sample_reg < adc_min_reg);

    always_comb
    begin
        priority if (det_off_reg)
            det_now = start_level_reg;
        else if (hold_now)
            det_now = prev_det_reg;
        else
            det_now = map_level;
    end

    assign sum_now = $signed({2'b00, det_now}) + 9'(corr_reg);

    always_comb
    begin
        priority if (sum_now[8])
            att_now = 7'd0;
        else if (sum_now[7])
            att_now = alc_pkg::LEVEL_MAX;
        else
            att_now = sum_now[6:0];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        corr_next  = corr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (op == alc_pkg::OP_MEASURE))
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                idx_next   = '0;
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                priority if (skip_reg)
                begin
                    corr_next  = '0;
                    state_next = ST_SUM;
                end
                else if ((temp_reg <= rd_temp) || (idx_reg == last_reg))
                begin
                    corr_next  = rd_corr;
                    state_next = ST_SUM;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_SUM:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            prev_det_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_SUM) && out_free && !hold_now)
                prev_det_reg <= det_now;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        corr_reg <= corr_next;
        if (in_accept)
        begin
            sample_reg <= adc_sample;
            temp_reg   <= temperature;
            last_reg   <= AW'(n_eff - CW'(1));
            skip_reg   <= tem_off_reg || (point_count_reg == 4'd0);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if ((state_reg == ST_SUM) && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_SUM) && out_free)
        begin
            att_level_reg <= att_now;
            det_level_reg <= det_now;
            temp_corr_reg <= corr_reg;
            held_reg      <= hold_now;
        end
    end

    assign out_valid = out_valid_reg;
    assign att_level = att_level_reg;
    assign det_level = det_level_reg;
    assign temp_corr = temp_corr_reg;
    assign held      = held_reg;

`ifndef SYNTHESIS
    a_sum_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) && out_free |=> (state_reg == ST_IDLE) && out_valid_reg)
        else $error("finished item not moved to output register");

    a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (op == alc_pkg::OP_WRITE) |=> (state_reg == ST_IDLE))
        else $error("table write item started a measurement");

    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) && !skip_reg |-> (idx_reg <= last_reg))
        else $error("table search ran past the last point");

    a_held_prev: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) && out_free && hold_now |=> (det_level_reg == $past(prev_det_reg)))
        else $error("held item did not reuse previous level");
`endif

endmodule
`default_nettype wire

### bench/attenuator_level_correction_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// attenuator_level_correction_tb
// Self-checking bench for the attenuator level correction block. A short
// directed run covers the coefficient extremes, half-up rounding, the held
// level, table search hits and misses, both correction switches, and clamping
// at both ends. Randomized phases follow, each with new register settings and
// a mix of table writes and measurements. Random input gaps and output stalls
// run throughout, except for one phase that has none. Each result is compared
// field by field with an in-bench predictor.
// ----------------------------------------------------------------------------
module attenuator_level_correction_tb;

    localparam int     CFG_IDX_W      = alc_pkg::CFG_IDX_W;
    localparam int     CFG_DATA_W     = alc_pkg::CFG_DATA_W;
    localparam int     TABLE_POINTS   = 8;
    localparam int     HALF_PERIOD    = 4;
    localparam int     RESET_CYCLES   = 9;
    localparam int     DRAIN_CYCLES   = 16;
    localparam int     STALL_LIMIT    = 4000;
    localparam int     IDLE_PERCENT   = 19;
    localparam int     WRITE_PERCENT  = 15;
    localparam int     RANDOM_PHASES  = 12;
    localparam int     PHASE_ITEMS    = 40;
    localparam longint ROUND_HALF_Q16 = 32768;

    typedef struct {
        logic [6:0]        att;
        logic [6:0]        det;
        logic signed [7:0] corr;
        logic              held;
    } level_result_t;

    class level_scoreboard;
        logic signed [31:0] gain_a;
        logic signed [31:0] offset_b;
        logic [15:0]        adc_min;
        logic [6:0]         start_level;
        logic               det_off;
        logic               tem_off;
        logic [3:0]         point_count;
        logic [6:0]         prev_level;
        logic signed [7:0]  table_temps [TABLE_POINTS];
        logic signed [7:0]  table_corrs [TABLE_POINTS];
        level_result_t      pending_levels [$];
        int errors;
        int checked;
        int table_writes;
        int held_count;
        int clamped_low;
        int clamped_high;
        int settings;

        function new();
            gain_a       = '0;
            offset_b     = '0;
            adc_min      = '0;
            start_level  = '0;
            det_off      = 1'b0;
            tem_off      = 1'b0;
            point_count  = '0;
            prev_level   = '0;
            errors       = 0;
            checked      = 0;
            table_writes = 0;
            held_count   = 0;
            clamped_low  = 0;
            clamped_high = 0;
            settings     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                alc_pkg::REG_GAIN_A:       gain_a      = value;
                alc_pkg::REG_OFFSET_B:     offset_b    = value;
                alc_pkg::REG_ADC_MIN:      adc_min     = value[15:0];
                alc_pkg::REG_START_LEVEL:  start_level = value[6:0];
                alc_pkg::REG_DET_CORR_OFF: det_off     = value[0];
                alc_pkg::REG_TEM_CORR_OFF: tem_off     = value[0];
                alc_pkg::REG_POINT_COUNT:  point_count = value[3:0];
                default: ;
            endcase
        endfunction

        function logic [6:0] detector_level(logic [15:0] sample);
            longint acc;
            acc = longint'(sample) * longint'(gain_a) + longint'(offset_b) + ROUND_HALF_Q16;
            if (acc < 0)
                return '0;
            acc = acc >>> 16;
            if (acc > 127)
                return alc_pkg::LEVEL_MAX;
            return 7'(acc);
        endfunction

        function logic signed [7:0] table_correction(logic signed [7:0] t);
            int n;
            n = (point_count > TABLE_POINTS) ? TABLE_POINTS : int'(point_count);
            if (n == 0)
                return '0;
            for (int i = 0; i < n; i++)
                if (t <= table_temps[i])
                    return table_corrs[i];
            return table_corrs[n-1];
        endfunction

        function void note_item(logic item_op, logic [15:0] sample, logic signed [7:0] t,
                                logic [2:0] idx, logic signed [7:0] et, logic signed [7:0] ec);
            level_result_t r;
            int sum;
            if (item_op == alc_pkg::OP_WRITE)
            begin
                table_temps[idx] = et;
                table_corrs[idx] = ec;
                table_writes++;
                return;
            end
            r.held = 1'b0;
            r.corr = '0;
            if (!det_off)
            begin
                if (sample < adc_min)
                begin
                    r.det = prev_level;
                    r.held = 1'b1;
                    held_count++;
                end
                else
                begin
                    r.det = detector_level(sample);
                    prev_level = r.det;
                end
            end
            else
            begin
                r.det = start_level;
                prev_level = r.det;
            end
            if (!tem_off)
                r.corr = table_correction(t);
            sum = int'(r.det) + int'(r.corr);
            if (sum < 0)
            begin
                sum = 0;
                clamped_low++;
            end
            if (sum > 127)
            begin
                sum = 127;
                clamped_high++;
            end
            r.att = 7'(sum);
            pending_levels.push_back(r);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch on %0s: got %0d, want %0d", what, got, want);
            errors++;
        endtask

        task check_result(logic [6:0] att, logic [6:0] det, logic signed [7:0] corr,
                          logic hold_flag);
            level_result_t e;
            if (pending_levels.size() == 0)
            begin
                report("result with nothing pending", int'(att), 0);
                return;
            end
            e = pending_levels.pop_front();
            checked++;
            if (att !== e.att)
                report("att_level", int'(att), int'(e.att));
            if (det !== e.det)
                report("det_level", int'(det), int'(e.det));
            if (corr !== e.corr)
                report("temp_corr", int'(corr), int'(e.corr));
            if (hold_flag !== e.held)
                report("held", int'(hold_flag), int'(e.held));
        endtask
    endclass

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index   = '0;
    logic [CFG_DATA_W-1:0]   cfg_data    = '0;
    logic                    in_valid    = 1'b0;
    logic                    op          = alc_pkg::OP_MEASURE;
    logic [15:0]             adc_sample  = '0;
    logic signed [7:0]       temperature = '0;
    logic [2:0]              entry_index = '0;
    logic signed [7:0]       entry_temp  = '0;
    logic signed [7:0]       entry_corr  = '0;
    logic                    out_stall   = 1'b0;
    logic                    in_stall;
    logic                    out_valid;
    logic [6:0]              att_level;
    logic [6:0]              det_level;
    logic signed [7:0]       temp_corr;
    logic                    held;
    logic                    idle_on     = 1'b1;
    int                      quiet_cycles = 0;
    level_scoreboard         sb = new();

    attenuator_level_correction #(.TABLE_POINTS(TABLE_POINTS)) u_dut (.*);

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_item(op, adc_sample, temperature, entry_index, entry_temp, entry_corr);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(att_level, det_level, temp_corr, held);
        if (rst_n && idle_on)
            out_stall <= ($urandom_range(99) < IDLE_PERCENT);
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("no progress for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_item(logic item_op, logic [15:0] sample, logic signed [7:0] t,
                             logic [2:0] idx, logic signed [7:0] et, logic signed [7:0] ec);
        while (idle_on && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= item_op;
        adc_sample  <= sample;
        temperature <= t;
        entry_index <= idx;
        entry_temp  <= et;
        entry_corr  <= ec;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_measure(logic [15:0] sample, logic signed [7:0] t);
        send_item(alc_pkg::OP_MEASURE, sample, t, 3'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic send_point(logic [2:0] idx, logic signed [7:0] et, logic signed [7:0] ec);
        send_item(alc_pkg::OP_WRITE, 16'($urandom), 8'($urandom), idx, et, ec);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_levels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic program_regs(logic [31:0] gain, logic [31:0] offset, logic [15:0] amin,
                                logic [6:0] start, logic det_dis, logic tem_dis,
                                logic [3:0] count);
        logic [CFG_DATA_W-1:0] vals [0:alc_pkg::REG_POINT_COUNT];
        drain();
        vals[alc_pkg::REG_GAIN_A]       = gain;
        vals[alc_pkg::REG_OFFSET_B]     = offset;
        vals[alc_pkg::REG_ADC_MIN]      = 32'(amin);
        vals[alc_pkg::REG_START_LEVEL]  = 32'(start);
        vals[alc_pkg::REG_DET_CORR_OFF] = 32'(det_dis);
        vals[alc_pkg::REG_TEM_CORR_OFF] = 32'(tem_dis);
        vals[alc_pkg::REG_POINT_COUNT]  = 32'(count);
        for (int i = alc_pkg::REG_GAIN_A; i <= alc_pkg::REG_POINT_COUNT; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            sb.set_reg(CFG_IDX_W'(i), vals[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        sb.settings++;
    endtask

    initial
    begin
        logic signed [7:0] point_temps [TABLE_POINTS];
        logic signed [7:0] point_corrs [TABLE_POINTS];
        logic [31:0]       gain;
        logic [31:0]       offset;
        logic [15:0]       amin;
        logic [15:0]       sample;
        int                mag;

        point_temps = '{-100, -50, -10, 0, 10, 40, 80, 127};
        point_corrs = '{-128, -20, -5, 0, 3, 20, 60, 127};

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < TABLE_POINTS; i++)
            send_point(3'(i), point_temps[i], point_corrs[i]);
        send_measure(16'h0000, -128);
        send_measure(16'hFFFF, 127);

        program_regs(32'h7FFF_FFFF, 32'h8000_0000, 16'h0100, 7'h7F, 1'b0, 1'b0, 4'hF);
        send_measure(16'h0100, 127);
        send_measure(16'h00FF, -128);
        send_measure(16'hFFFF, -10);

        program_regs(32'h8000_0000, 32'h7FFF_FFFF, 16'h0000, 7'h00, 1'b0, 1'b1, 4'h0);
        send_measure(16'h0000, 0);
        send_measure(16'h0001, 55);
        send_measure(16'hFFFF, -1);

        program_regs(32'h0000_0000, 32'h0005_8000, 16'hFFFF, 7'h00, 1'b0, 1'b0, 4'h3);
        send_measure(16'hFFFF, 127);
        send_measure(16'hFFFE, -50);

        program_regs(32'h0000_0000, 32'h0000_0000, 16'hFFFF, 7'h55, 1'b1, 1'b0, 4'h8);
        send_measure(16'h0000, 40);

        program_regs(32'h0000_0000, 32'h0000_0000, 16'hFFFF, 7'h00, 1'b0, 1'b1, 4'h8);
        send_measure(16'h0000, 0);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case ($urandom_range(7))
                0: gain = 32'h7FFF_FFFF;
                1: gain = 32'h8000_0000;
                2: gain = $urandom;
                3: gain = '0;
                default:
                begin
                    mag = $urandom_range(400);
                    gain = $urandom_range(1) ? 32'(-mag) : 32'(mag);
                end
            endcase
            if ($urandom_range(3) == 0)
                offset = $urandom;
            else
                offset = 32'(int'($urandom_range(320 * 65536)) - 160 * 65536);
            case ($urandom_range(9))
                0, 1, 2, 3, 4: amin = '0;
                5:             amin = 16'hFFFF;
                default:       amin = 16'($urandom);
            endcase
            program_regs(gain, offset, amin, 7'($urandom),
                         $urandom_range(99) < 20, $urandom_range(99) < 20,
                         4'($urandom_range(15)));
            idle_on <= (p != RANDOM_PHASES / 2);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(99) < WRITE_PERCENT)
                    send_point(3'($urandom), 8'($urandom), 8'($urandom));
                else
                begin
                    if ($urandom_range(3) == 0)
                        sample = amin + 16'($urandom_range(4)) - 16'd2;
                    else
                        sample = 16'($urandom);
                    send_measure(sample, 8'($urandom));
                end
            end
        end

        drain();
        $display("checked %0d measurements and %0d table writes over %0d register settings",
                 sb.checked, sb.table_writes, sb.settings);
        $display("%0d held levels, %0d sums clamped at zero, %0d clamped at full scale",
                 sb.held_count, sb.clamped_low, sb.clamped_high);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### files.f
rtl/alc_pkg.sv
rtl/alc_table.sv
rtl/alc_det_map.sv
rtl/attenuator_level_correction.sv
bench/attenuator_level_correction_tb.sv
